// File: hw/rtl/irpwd_pkg.sv
// Package for the IR pulse-width packet decoder.
// Holds configuration register indexes, reset values and shared widths.
// No dependencies.
package irpwd_pkg;

    localparam int WORD_BITS_DEFAULT  = 32;
    localparam int COUNT_BITS_DEFAULT = 16;

    localparam int THRESH_BITS   = 16;
    localparam int CODE_BITS     = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_ONE_PULSE_MIN = 3'd0;
    localparam cfg_idx_t CFG_ONE_PULSE_MAX = 3'd1;
    localparam cfg_idx_t CFG_TIMEOUT_TICKS = 3'd2;
    localparam cfg_idx_t CFG_CODE_FIRST    = 3'd3;
    localparam cfg_idx_t CFG_CODE_SECOND   = 3'd4;

    localparam logic [THRESH_BITS-1:0] ONE_PULSE_MIN_RESET = 16'd1400;
    localparam logic [THRESH_BITS-1:0] ONE_PULSE_MAX_RESET = 16'd2000;
    localparam logic [THRESH_BITS-1:0] TIMEOUT_TICKS_RESET = 16'hFFFF;
    localparam logic [CODE_BITS-1:0]   CODE_RESET          = 32'd0;

endpackage

// File: hw/rtl/ir_pulse_width_packet_decoder.sv
// Top level of the IR pulse-width packet decoder: edge timing, bit shifting,
// packet timeout, button code match and LED toggles, with a registered output.
// Depends on irpwd_pkg.
//
//  channel | signals                                   | word
//  --------+-------------------------------------------+------------------------------
//  in      | in_valid, in_ready                        | ir_level
//  out     | out_valid, out_ready                      | packet_done, packet_word,
//          |                                           | led_first, led_second
//  cfg     | cfg_we, cfg_index, cfg_data               | register write, no handshake
//
// One word per cycle while the output is not stalled: each accepted tick updates
// state and its result lands in the output register on the same edge.
// in_ready is high while the output register is empty or being drained.
// Reset (rst_n low, asynchronous) restores the registers to their defaults,
// the line to idle high, the counter and shift word to zero and both LED states off.
// A stalled output holds its word; input is taken only when it can be stored.
module ir_pulse_width_packet_decoder #(
    parameter int WORD_BITS  = irpwd_pkg::WORD_BITS_DEFAULT,
    parameter int COUNT_BITS = irpwd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               ir_level,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               packet_done,
    output logic [irpwd_pkg::CODE_BITS-1:0]    packet_word,
    output logic                               led_first,
    output logic                               led_second,
    input  logic                               cfg_we,
    input  irpwd_pkg::cfg_idx_t                cfg_index,
    input  logic [irpwd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int TB = irpwd_pkg::THRESH_BITS;
    localparam int CB = irpwd_pkg::CODE_BITS;
    localparam int LEN_BITS = (COUNT_BITS > TB) ? COUNT_BITS : TB;
    localparam int CMP_BITS = (WORD_BITS > CB) ? WORD_BITS : CB;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [TB-1:0]         one_pulse_min_reg;
    logic [TB-1:0]         one_pulse_max_reg;
    logic [TB-1:0]         timeout_ticks_reg;
    logic [CB-1:0]         code_first_reg;
    logic [CB-1:0]         code_second_reg;

    logic                  last_level_reg;
    logic [COUNT_BITS-1:0] tick_count_reg;
    logic                  timeout_armed_reg;
    logic [WORD_BITS-1:0]  shift_word_reg;
    logic                  led_first_reg;
    logic                  led_second_reg;

    logic                  out_valid_reg;
    logic                  packet_done_reg;
    logic [CB-1:0]         packet_word_reg;
    logic                  led_first_out_reg;
    logic                  led_second_out_reg;

    logic                  last_level_next;
    logic [COUNT_BITS-1:0] tick_count_next;
    logic                  timeout_armed_next;
    logic [WORD_BITS-1:0]  shift_word_next;
    logic                  led_first_next;
    logic                  led_second_next;
    logic                  done_next;
    logic [CB-1:0]         word_next;

    logic                  accept;
    logic                  level_edge;
    logic [COUNT_BITS-1:0] count_inc;
    logic [LEN_BITS-1:0]   len_ext;
    logic [LEN_BITS-1:0]   inc_ext;
    logic                  pulse_bit;
    logic                  timeout_hit;
    logic [CMP_BITS-1:0]   word_ext;
    logic                  match_first;
    logic                  match_second;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_pulse_min_reg <= irpwd_pkg::ONE_PULSE_MIN_RESET;
            one_pulse_max_reg <= irpwd_pkg::ONE_PULSE_MAX_RESET;
            timeout_ticks_reg <= irpwd_pkg::TIMEOUT_TICKS_RESET;
            code_first_reg    <= irpwd_pkg::CODE_RESET;
            code_second_reg   <= irpwd_pkg::CODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                irpwd_pkg::CFG_ONE_PULSE_MIN: one_pulse_min_reg <= cfg_data[TB-1:0];
                irpwd_pkg::CFG_ONE_PULSE_MAX: one_pulse_max_reg <= cfg_data[TB-1:0];
                irpwd_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TB-1:0];
                irpwd_pkg::CFG_CODE_FIRST:    code_first_reg    <= cfg_data[CB-1:0];
                irpwd_pkg::CFG_CODE_SECOND:   code_second_reg   <= cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        level_edge  = (ir_level != last_level_reg);
        count_inc   = (tick_count_reg == COUNT_MAX) ? tick_count_reg
                                                    : tick_count_reg + 1'b1;
        len_ext     = LEN_BITS'(tick_count_reg);
        inc_ext     = LEN_BITS'(count_inc);
        pulse_bit   = (len_ext > LEN_BITS'(one_pulse_min_reg))
                   && (len_ext < LEN_BITS'(one_pulse_max_reg));
        timeout_hit = timeout_armed_reg && (inc_ext >= LEN_BITS'(timeout_ticks_reg));
        word_ext    = CMP_BITS'(shift_word_reg);
        match_first  = (word_ext == CMP_BITS'(code_first_reg));
        match_second = (word_ext == CMP_BITS'(code_second_reg));

        last_level_next    = ir_level;
        tick_count_next    = count_inc;
        timeout_armed_next = timeout_armed_reg;
        shift_word_next    = shift_word_reg;
        led_first_next     = led_first_reg;
        led_second_next    = led_second_reg;
        done_next          = 1'b0;
        word_next          = '0;

        if (level_edge)
        begin
            tick_count_next = '0;
            if (!ir_level)
            begin
                shift_word_next = {shift_word_reg[WORD_BITS-2:0], pulse_bit};
            end
            else
            begin
                timeout_armed_next = 1'b1;
            end
        end
        else if (timeout_hit)
        begin
            done_next          = 1'b1;
            word_next          = word_ext[CB-1:0];
            shift_word_next    = '0;
            timeout_armed_next = 1'b0;
            tick_count_next    = '0;
            if (match_first)
            begin
                led_first_next = !led_first_reg;
            end
            else if (match_second)
            begin
                led_second_next = !led_second_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg    <= 1'b1;
            tick_count_reg    <= '0;
            timeout_armed_reg <= 1'b0;
            shift_word_reg    <= '0;
            led_first_reg     <= 1'b0;
            led_second_reg    <= 1'b0;
        end
        else if (accept)
        begin
            last_level_reg    <= last_level_next;
            tick_count_reg    <= tick_count_next;
            timeout_armed_reg <= timeout_armed_next;
            shift_word_reg    <= shift_word_next;
            led_first_reg     <= led_first_next;
            led_second_reg    <= led_second_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            packet_done_reg    <= done_next;
            packet_word_reg    <= word_next;
            led_first_out_reg  <= led_first_next;
            led_second_out_reg <= led_second_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign packet_done = packet_done_reg;
    assign packet_word = packet_word_reg;
    assign led_first   = led_first_out_reg;
    assign led_second  = led_second_out_reg;

    a_word_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !packet_done) |-> (packet_word == '0))
        else $error("packet word nonzero without packet done");

    a_done_clears_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done_next) |=> (!timeout_armed_reg && shift_word_reg == '0
                                   && tick_count_reg == '0))
        else $error("packet end did not clear word, timeout and counter");

    a_led_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !done_next) |=> (led_first_reg == $past(led_first_reg)
                                    && led_second_reg == $past(led_second_reg)))
        else $error("LED toggled without a completed packet");

    a_rise_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && level_edge && ir_level) |=> (timeout_armed_reg && tick_count_reg == '0))
        else $error("rising edge did not arm timeout");

endmodule
